>>> src/tmsp_pkg.sv
package tmsp_pkg;

	// event type codes on report_ch
	localparam logic [2:0] EV_MOVE   = 3'd0;
	localparam logic [2:0] EV_DRAG   = 3'd1;
	localparam logic [2:0] EV_SCROLL = 3'd2;
	localparam logic [2:0] EV_DOWN   = 3'd3;
	localparam logic [2:0] EV_UP     = 3'd4;

	// result kind codes
	localparam logic RES_EVENT = 1'b0;
	localparam logic RES_STOP  = 1'b1;

	// one finished report or stop, passed from the parser to the decoder
	typedef struct packed {
		logic        stop;
		logic        sgr;
		logic        press;
		logic [7:0]  code;
		logic [16:0] x;
		logic [16:0] y;
		logic        last;
	} report_t;

endpackage

>>> src/tmsp_if.sv
interface tmsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_of_buffer;

	modport source (output valid, byte_in, last_of_buffer, input ready);
	modport sink (input valid, byte_in, last_of_buffer, output ready);
endinterface

interface tmsp_report_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [2:0]         event_type;
	logic signed [2:0]  button;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic [1:0]         scroll_dir;
	logic               shift_held;
	logic               alt_held;
	logic               ctrl_held;
	logic               buffer_end;
	logic [15:0]        events_in_buffer;

	modport source (output valid, result_kind, event_type, button, pos_x, pos_y, scroll_dir,
		shift_held, alt_held, ctrl_held, buffer_end, events_in_buffer, input ready);
	modport sink (input valid, result_kind, event_type, button, pos_x, pos_y, scroll_dir,
		shift_held, alt_held, ctrl_held, buffer_end, events_in_buffer, output ready);
endinterface

>>> src/tmsp_front.sv
module tmsp_front #(
	parameter int FIELD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	tmsp_byte_if.sink          byte_ch,
	input  logic               q_full,
	output logic               q_push,
	output tmsp_pkg::report_t  q_item
);

	localparam logic [7:0] CH_ESC      = 8'h1b;
	localparam logic [7:0] CH_LBRACKET = 8'h5b;
	localparam logic [7:0] CH_LT       = 8'h3c;
	localparam logic [7:0] CH_PRESS    = 8'h4d;
	localparam logic [7:0] CH_RELEASE  = 8'h6d;
	localparam logic [7:0] CH_SEMI     = 8'h3b;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam int         WIDE_W      = FIELD_BITS + 4;
	localparam int         EXT_W       = FIELD_BITS + 17;
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_BRACKET,
		PH_SGR,
		PH_X10_B,
		PH_X10_C,
		PH_X10_R
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [1:0]            field_q, field_d;
	logic                  seen_q, seen_d;
	logic [FIELD_BITS-1:0] bacc_q, bacc_d;
	logic [FIELD_BITS-1:0] cacc_q, cacc_d;
	logic [FIELD_BITS-1:0] racc_q, racc_d;
	logic                  stopped_q, stopped_d;

	logic                  accept;
	logic [7:0]            c;
	logic                  last;
	logic                  ev;
	logic                  stop;
	logic                  is_digit;
	logic [FIELD_BITS-1:0] sel_acc;
	logic [WIDE_W-1:0]     wide;
	logic [FIELD_BITS-1:0] sat;
	logic [EXT_W-1:0]      bext;
	logic [EXT_W-1:0]      cext;
	logic [EXT_W-1:0]      rext;

	assign byte_ch.ready = !q_full;
	assign accept = byte_ch.valid && byte_ch.ready;
	assign c = byte_ch.byte_in;
	assign last = byte_ch.last_of_buffer;

	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign sel_acc = (field_q == 2'd0) ? bacc_q : (field_q == 2'd1) ? cacc_q : racc_q;
	// acc * 10 + digit, then clamp to the field maximum
	assign wide = ({4'b0, sel_acc} << 3) + ({4'b0, sel_acc} << 1)
		+ {{(WIDE_W-4){1'b0}}, c[3:0]};
	assign sat = (wide > {4'b0, FIELD_MAX}) ? FIELD_MAX : wide[FIELD_BITS-1:0];

	assign bext = {17'b0, bacc_q};
	assign cext = {17'b0, cacc_q};
	assign rext = {17'b0, racc_q};

	always_comb begin
		phase_d = phase_q;
		field_d = field_q;
		seen_d = seen_q;
		bacc_d = bacc_q;
		cacc_d = cacc_q;
		racc_d = racc_q;
		stopped_d = stopped_q;
		ev = 1'b0;
		stop = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (c == CH_ESC) phase_d = PH_ESC; else stop = 1'b1;
			end
			PH_ESC: begin
				if (c == CH_LBRACKET) phase_d = PH_BRACKET; else stop = 1'b1;
			end
			PH_BRACKET: begin
				if (c == CH_LT) begin
					phase_d = PH_SGR;
					field_d = 2'd0;
					seen_d = 1'b0;
				end else if (c == CH_PRESS) begin
					phase_d = PH_X10_B;
				end else begin
					stop = 1'b1;
				end
			end
			PH_SGR: begin
				if (is_digit) begin
					seen_d = 1'b1;
					if (field_q == 2'd0) bacc_d = sat;
					else if (field_q == 2'd1) cacc_d = sat;
					else racc_d = sat;
				end else if (c == CH_SEMI) begin
					if (!seen_q || field_q >= 2'd2) begin
						stop = 1'b1;
					end else begin
						field_d = field_q + 2'd1;
						seen_d = 1'b0;
					end
				end else if (c == CH_PRESS || c == CH_RELEASE) begin
					if (!seen_q || field_q != 2'd2) stop = 1'b1;
					else ev = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end
			PH_X10_B: begin
				bacc_d = {{(FIELD_BITS-8){1'b0}}, c};
				phase_d = PH_X10_C;
			end
			PH_X10_C: begin
				cacc_d = {{(FIELD_BITS-8){1'b0}}, c};
				phase_d = PH_X10_R;
			end
			PH_X10_R: ev = 1'b1;
			default: stop = 1'b1;
		endcase

		// buffer ending mid-report
		if (!ev && !stop && last) stop = 1'b1;

		if (stopped_q) begin
			ev = 1'b0;
			stop = 1'b0;
			phase_d = phase_q;
			field_d = field_q;
			seen_d = seen_q;
			bacc_d = bacc_q;
			cacc_d = cacc_q;
			racc_d = racc_q;
		end

		if (last || ev || stop) begin
			phase_d = PH_IDLE;
			field_d = 2'd0;
			seen_d = 1'b0;
			bacc_d = '0;
			cacc_d = '0;
			racc_d = '0;
			stopped_d = !last && (stop || stopped_q);
		end
	end

	assign q_push = accept && (ev || stop);

	always_comb begin
		q_item.stop = stop;
		q_item.sgr = (phase_q == PH_SGR);
		q_item.press = (c == CH_PRESS);
		q_item.code = bext[7:0];
		q_item.x = cext[16:0];
		q_item.y = (phase_q == PH_SGR) ? rext[16:0] : {9'b0, c};
		q_item.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			field_q <= 2'd0;
			seen_q <= 1'b0;
			bacc_q <= '0;
			cacc_q <= '0;
			racc_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			field_q <= field_d;
			seen_q <= seen_d;
			bacc_q <= bacc_d;
			cacc_q <= cacc_d;
			racc_q <= racc_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

>>> src/tmsp_queue.sv
module tmsp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tmsp_pkg::report_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output tmsp_pkg::report_t pop_item
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tmsp_pkg::report_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> src/tmsp_back.sv
module tmsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tmsp_pkg::report_t q_item,
	output logic              q_pop,
	tmsp_report_if.source     report_ch
);

	localparam logic [7:0] X10_BIAS  = 8'd32;
	localparam logic [16:0] SGR_POS_BIAS = 17'd1;
	localparam logic [16:0] X10_POS_BIAS = 17'd33;

	logic               valid_q;
	logic               kind_q;
	logic [2:0]         type_q;
	logic signed [2:0]  button_q;
	logic signed [16:0] pos_x_q;
	logic signed [16:0] pos_y_q;
	logic [1:0]         dir_q;
	logic               shift_q;
	logic               alt_q;
	logic               ctrl_q;
	logic               end_q;
	logic [15:0]        events_q;
	logic               held_q;
	logic [15:0]        count_q;

	logic [7:0]  code;
	logic [1:0]  btn;
	logic [2:0]  ev_type;
	logic [2:0]  ev_button;
	logic [1:0]  ev_dir;
	logic [16:0] ev_x;
	logic [16:0] ev_y;
	logic        held_d;
	logic [15:0] count_inc;

	assign q_pop = q_valid && (!valid_q || report_ch.ready);

	assign code = q_item.sgr ? q_item.code : q_item.code - X10_BIAS;
	assign btn = code[1:0];
	assign count_inc = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;

	always_comb begin
		held_d = held_q;
		ev_dir = 2'd0;
		if (q_item.sgr) begin
			ev_button = (btn == 2'd3) ? 3'd0 : {1'b0, btn};
			if (code[5]) begin
				ev_type = (btn == 2'd3 || !held_q) ? tmsp_pkg::EV_MOVE : tmsp_pkg::EV_DRAG;
			end else if (code[6] && q_item.press) begin
				ev_type = tmsp_pkg::EV_SCROLL;
				ev_dir = btn;
			end else if (q_item.press) begin
				ev_type = tmsp_pkg::EV_DOWN;
				if (btn != 2'd3) held_d = 1'b1;
			end else begin
				ev_type = tmsp_pkg::EV_UP;
				held_d = 1'b0;
			end
			ev_x = q_item.x - SGR_POS_BIAS;
			ev_y = q_item.y - SGR_POS_BIAS;
		end else begin
			if (code[5]) begin
				ev_type = tmsp_pkg::EV_MOVE;
				// motion with no button reads as -1
				ev_button = (btn == 2'd3) ? 3'b111 : {1'b0, btn};
			end else if (code[6]) begin
				ev_type = tmsp_pkg::EV_SCROLL;
				ev_button = 3'd0;
				ev_dir = btn;
			end else begin
				ev_type = (btn == 2'd3) ? tmsp_pkg::EV_UP : tmsp_pkg::EV_DOWN;
				ev_button = (btn == 2'd3) ? 3'd0 : {1'b0, btn};
			end
			ev_x = q_item.x - X10_POS_BIAS;
			ev_y = q_item.y - X10_POS_BIAS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			held_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				if (q_item.stop) begin
					// after a stop nothing counts until the buffer restarts
					count_q <= '0;
				end else begin
					held_q <= held_d;
					count_q <= q_item.last ? '0 : count_inc;
				end
			end else if (report_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_item.stop ? tmsp_pkg::RES_STOP : tmsp_pkg::RES_EVENT;
			end_q <= q_item.last;
			if (q_item.stop) begin
				type_q <= '0;
				button_q <= '0;
				pos_x_q <= '0;
				pos_y_q <= '0;
				dir_q <= '0;
				shift_q <= 1'b0;
				alt_q <= 1'b0;
				ctrl_q <= 1'b0;
				events_q <= count_q;
			end else begin
				type_q <= ev_type;
				button_q <= ev_button;
				pos_x_q <= ev_x;
				pos_y_q <= ev_y;
				dir_q <= ev_dir;
				shift_q <= code[2];
				alt_q <= code[3];
				ctrl_q <= code[4];
				events_q <= count_inc;
			end
		end
	end

	assign report_ch.valid = valid_q;
	assign report_ch.result_kind = kind_q;
	assign report_ch.event_type = type_q;
	assign report_ch.button = button_q;
	assign report_ch.pos_x = pos_x_q;
	assign report_ch.pos_y = pos_y_q;
	assign report_ch.scroll_dir = dir_q;
	assign report_ch.shift_held = shift_q;
	assign report_ch.alt_held = alt_q;
	assign report_ch.ctrl_held = ctrl_q;
	assign report_ch.buffer_end = end_q;
	assign report_ch.events_in_buffer = events_q;

endmodule

>>> src/terminal_mouse_sequence_parser.sv
// Terminal mouse report parser.
// byte_ch takes one terminal byte per transfer, with last_of_buffer set on the
// final byte of each input buffer. report_ch gives one transfer per finished
// SGR or X10 mouse report, and one stop transfer per buffer that holds a
// malformed byte or ends partway through a report.
// A byte is taken every cycle while the two-entry report queue has room; bytes
// inside a report and bytes after a stop give no transfer at all.
// A report's result goes from the transfer of its final byte through the report
// queue and then the decoder's output register before it reaches report_ch.
// Sustained rate is one byte per cycle while the report queue has room.
// When report_ch stalls, the output register holds its result, the queue
// fills, and byte_ch.ready drops once both queue entries are taken.
// Reset clears the parser to wait for an escape byte, empties the queue,
// drops the output valid, clears the held-button flag and the event count.
// FIELD_BITS sets the saturation width of the decimal SGR fields.
module terminal_mouse_sequence_parser #(
	parameter int FIELD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tmsp_byte_if.sink     byte_ch,
	tmsp_report_if.source report_ch
);

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	tmsp_pkg::report_t push_item;
	tmsp_pkg::report_t pop_item;

	tmsp_front #(
		.FIELD_BITS (FIELD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	tmsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (pop_item)
	);

	tmsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.report_ch (report_ch)
	);

	// no report may be dropped at the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("report pushed into a full queue");

	a_stop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		report_ch.valid && report_ch.result_kind == tmsp_pkg::RES_STOP |->
			report_ch.event_type == 3'd0 && report_ch.button == 3'sd0 &&
			report_ch.pos_x == 17'sd0 && report_ch.pos_y == 17'sd0 &&
			report_ch.scroll_dir == 2'd0)
		else $error("stop result carries event fields");

	a_event_counted: assert property (@(posedge clk) disable iff (!arst_n)
		report_ch.valid && report_ch.result_kind == tmsp_pkg::RES_EVENT |->
			report_ch.events_in_buffer != 16'd0)
		else $error("event result with zero event count");

	a_dir_scroll_only: assert property (@(posedge clk) disable iff (!arst_n)
		report_ch.valid && report_ch.event_type != tmsp_pkg::EV_SCROLL |->
			report_ch.scroll_dir == 2'd0)
		else $error("scroll direction on a non-scroll result");

	// a result entering the output register came out of the queue
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid ##1 report_ch.valid)
		else $error("decoder took a report from an empty queue");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int          CLK_HALF    = 4;
	localparam int          RESET_LEN   = 11;
	localparam int          RANDOM_LEN  = 1050;
	localparam int          GAP_MAX     = 14;
	localparam int          HOLD_LEN    = 250;
	localparam int          IDLE_LIMIT  = 4000;
	localparam int          DRAIN_LEN   = 20;
	localparam int unsigned FIELD_MAX   = 32'd65535;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_BRK   = 8'h5b;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PRESS = 8'h4d;
	localparam logic [7:0] CH_REL   = 8'h6d;

	typedef enum logic [2:0] {PH_IDLE, PH_ESC, PH_BRACKET, PH_SGR, PH_X10_BTN, PH_X10_POS} phase_e;

	typedef struct packed {
		logic               kind;
		logic [2:0]         etype;
		logic signed [2:0]  btn;
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [1:0]         dir;
		logic               shift;
		logic               alt;
		logic               ctrl;
		logic               bend;
		logic [15:0]        nev;
	} mouse_result_t;

	typedef struct {
		logic [7:0]    b;
		logic          l;
		bit            typed;
		bit            has;
		mouse_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tmsp_byte_if   byte_ch ();
	tmsp_report_if report_ch ();

	terminal_mouse_sequence_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.report_ch (report_ch)
	);

	mouse_result_t pending_reports[$];
	stim_row_t     dir_rows[$];
	logic [7:0]    frame_bytes[$];
	int            fail_count;
	int            reports_seen;
	bit            burst;
	bit            rx_holding;

	// parser state as predicted
	phase_e      st_phase;
	logic [1:0]  st_field;
	logic        st_digit;
	logic [15:0] st_btn;
	logic [15:0] st_col;
	logic [15:0] st_row;
	logic        st_held;
	logic        st_stopped;
	logic [15:0] st_count;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void clear_report();
		st_phase = PH_IDLE;
		st_field = '0;
		st_digit = 1'b0;
		st_btn   = '0;
		st_col   = '0;
		st_row   = '0;
	endfunction

	function automatic void clear_buffer();
		clear_report();
		st_stopped = 1'b0;
		st_count   = '0;
	endfunction

	function automatic mouse_result_t stop_result(input logic [15:0] nev, input logic bend);
		mouse_result_t r;
		r      = '0;
		r.kind = tmsp_pkg::RES_STOP;
		r.bend = bend;
		r.nev  = nev;
		return r;
	endfunction

	// advances the predicted parser by one byte, returns 1 when a report transfer follows
	function automatic bit decode_byte(input logic [7:0] c, input logic l, output mouse_result_t r);
		bit          ev;
		bit          stop;
		bit          press;
		logic [31:0] acc_v;
		logic [1:0]  btn2;
		logic [7:0]  code;
		ev   = 1'b0;
		stop = 1'b0;
		r    = '0;
		if (st_stopped) begin
			if (l) clear_buffer();
			return 1'b0;
		end
		case (st_phase)
			PH_IDLE: begin
				if (c == CH_ESC) st_phase = PH_ESC;
				else stop = 1'b1;
			end
			PH_ESC: begin
				if (c == CH_BRK) st_phase = PH_BRACKET;
				else stop = 1'b1;
			end
			PH_BRACKET: begin
				if (c == CH_LT) begin
					st_phase = PH_SGR;
					st_field = '0;
					st_digit = 1'b0;
				end else if (c == CH_PRESS) begin
					st_phase = PH_X10_BTN;
				end else begin
					stop = 1'b1;
				end
			end
			PH_SGR: begin
				if (c >= CH_0 && c <= CH_9) begin
					acc_v = (st_field == 2'd0 ? st_btn : st_field == 2'd1 ? st_col : st_row)
						* 32'd10 + (c - CH_0);
					if (acc_v > FIELD_MAX) acc_v = FIELD_MAX;
					case (st_field)
						2'd0:    st_btn = acc_v[15:0];
						2'd1:    st_col = acc_v[15:0];
						default: st_row = acc_v[15:0];
					endcase
					st_digit = 1'b1;
				end else if (c == CH_SEMI) begin
					if (!st_digit || st_field >= 2'd2) begin
						stop = 1'b1;
					end else begin
						st_field = st_field + 2'd1;
						st_digit = 1'b0;
					end
				end else if (c == CH_PRESS || c == CH_REL) begin
					if (!st_digit || st_field != 2'd2) begin
						stop = 1'b1;
					end else begin
						press = (c == CH_PRESS);
						btn2  = st_btn[1:0];
						if (st_btn[5]) begin
							r.etype = (btn2 == 2'd3 || !st_held) ? tmsp_pkg::EV_MOVE
								: tmsp_pkg::EV_DRAG;
						end else if (st_btn[6] && press) begin
							r.etype = tmsp_pkg::EV_SCROLL;
							r.dir   = btn2;
						end else if (press) begin
							r.etype = tmsp_pkg::EV_DOWN;
							if (btn2 != 2'd3) st_held = 1'b1;
						end else begin
							r.etype = tmsp_pkg::EV_UP;
							st_held = 1'b0;
						end
						r.btn   = (btn2 == 2'd3) ? 3'sd0 : {1'b0, btn2};
						r.x     = {1'b0, st_col} - 17'd1;
						r.y     = {1'b0, st_row} - 17'd1;
						r.shift = st_btn[2];
						r.alt   = st_btn[3];
						r.ctrl  = st_btn[4];
						ev      = 1'b1;
						clear_report();
					end
				end else begin
					stop = 1'b1;
				end
			end
			PH_X10_BTN: begin
				st_btn   = {8'h00, c};
				st_phase = PH_X10_POS;
			end
			PH_X10_POS: begin
				if (st_field == 2'd0) begin
					st_col   = {8'h00, c};
					st_field = 2'd1;
				end else begin
					code = st_btn[7:0] - 8'd32;
					btn2 = code[1:0];
					if (code[5]) begin
						r.etype = tmsp_pkg::EV_MOVE;
						// motion with no button reports -1
						r.btn   = (btn2 == 2'd3) ? -3'sd1 : {1'b0, btn2};
					end else if (code[6]) begin
						r.etype = tmsp_pkg::EV_SCROLL;
						r.btn   = 3'sd0;
						r.dir   = btn2;
					end else begin
						r.etype = (btn2 == 2'd3) ? tmsp_pkg::EV_UP : tmsp_pkg::EV_DOWN;
						r.btn   = (btn2 == 2'd3) ? 3'sd0 : {1'b0, btn2};
					end
					r.x     = {9'h000, st_col[7:0]} - 17'd33;
					r.y     = {9'h000, c} - 17'd33;
					r.shift = code[2];
					r.alt   = code[3];
					r.ctrl  = code[4];
					ev      = 1'b1;
					clear_report();
				end
			end
			default: stop = 1'b1;
		endcase

		if (!ev && !stop && l) stop = 1'b1;
		if (ev) begin
			if (st_count != 16'hffff) st_count = st_count + 16'd1;
			r.kind = tmsp_pkg::RES_EVENT;
		end else if (stop) begin
			r = stop_result(st_count, 1'b0);
		end
		r.bend = l;
		r.nev  = st_count;

		if (l) begin
			clear_buffer();
		end else if (stop) begin
			clear_report();
			st_stopped = 1'b1;
		end
		return ev || stop;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input bit typed, input bit t_has,
		input mouse_result_t t_res);
		int            gap;
		bit            has;
		mouse_result_t r;
		gap = (burst || rx_holding) ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid          <= 1'b1;
		byte_ch.byte_in        <= b;
		byte_ch.last_of_buffer <= l;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		has = decode_byte(b, l, r);
		if (typed) begin
			has = t_has;
			r   = t_res;
		end
		if (has) pending_reports.push_back(r);
	endtask

	task automatic add_row(input logic [7:0] b, input logic l, input bit typed, input bit has,
		input mouse_result_t res);
		stim_row_t row;
		row.b     = b;
		row.l     = l;
		row.typed = typed;
		row.has   = has;
		row.res   = res;
		dir_rows.push_back(row);
	endtask

	// decimal field, sometimes long enough to saturate
	task automatic add_field(input int unsigned hi);
		string s;
		int    n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(5, 7);
			for (int i = 0; i < n; i++) frame_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
		end else begin
			s = $sformatf("%0d", $urandom_range(0, hi));
			for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
		end
	endtask

	task automatic build_report();
		frame_bytes.delete();
		frame_bytes.push_back(CH_ESC);
		frame_bytes.push_back(CH_BRK);
		if ($urandom_range(0, 2) == 0) begin
			frame_bytes.push_back(CH_PRESS);
			repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			frame_bytes.push_back(CH_LT);
			add_field(127);
			frame_bytes.push_back(CH_SEMI);
			add_field($urandom_range(0, 3) == 0 ? 65535 : 400);
			frame_bytes.push_back(CH_SEMI);
			add_field($urandom_range(0, 3) == 0 ? 65535 : 400);
			frame_bytes.push_back($urandom_range(0, 1) ? CH_PRESS : CH_REL);
		end
	endtask

	// watchdog on cycles with no transfer on either channel
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (report_ch.valid && report_ch.ready)) idle = 0;
			else idle++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side
	initial begin
		int            gap;
		mouse_result_t exp_r;
		report_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = burst ? 0 : $urandom_range(0, GAP_MAX);
			if (reports_seen == 20 || reports_seen == 60) begin
				// long hold-off so the report queue fills and byte_ch stalls
				report_ch.ready <= 1'b0;
				rx_holding = 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				rx_holding = 1'b0;
			end else if (gap > 0) begin
				report_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			report_ch.ready <= 1'b1;
			@(posedge clk);
			while (!report_ch.valid) @(posedge clk);
			if (pending_reports.size() == 0) begin
				$error("unexpected transfer: result_kind %0d, events_in_buffer %0d",
					report_ch.result_kind, report_ch.events_in_buffer);
				fail_count++;
			end else begin
				exp_r = pending_reports.pop_front();
				check_field("result_kind", int'(exp_r.kind), int'(report_ch.result_kind));
				check_field("event_type", int'(exp_r.etype), int'(report_ch.event_type));
				check_field("button", int'(exp_r.btn), int'(report_ch.button));
				check_field("pos_x", int'(exp_r.x), int'(report_ch.pos_x));
				check_field("pos_y", int'(exp_r.y), int'(report_ch.pos_y));
				check_field("scroll_dir", int'(exp_r.dir), int'(report_ch.scroll_dir));
				check_field("shift_held", int'(exp_r.shift), int'(report_ch.shift_held));
				check_field("alt_held", int'(exp_r.alt), int'(report_ch.alt_held));
				check_field("ctrl_held", int'(exp_r.ctrl), int'(report_ch.ctrl_held));
				check_field("buffer_end", int'(exp_r.bend), int'(report_ch.buffer_end));
				check_field("events_in_buffer", int'(exp_r.nev),
					int'(report_ch.events_in_buffer));
			end
			reports_seen++;
		end
	end

	// byte side
	initial begin
		int         sent;
		int         nrep;
		bit         cut;
		logic [7:0] buf_bytes[$];
		arst_n                 = 1'b0;
		byte_ch.valid          = 1'b0;
		byte_ch.byte_in        = '0;
		byte_ch.last_of_buffer = 1'b0;
		fail_count             = 0;
		reports_seen           = 0;
		burst                  = 1'b0;
		rx_holding             = 1'b0;
		clear_buffer();
		st_held = 1'b0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte at the start, then silent restart on the buffer's final byte
		add_row(8'h41, 1'b0, 1, 1, stop_result(16'd0, 1'b0));
		add_row(CH_ESC, 1'b1, 1, 0, '0);
		// buffer ends mid-report
		add_row(CH_ESC, 1'b1, 1, 1, stop_result(16'd0, 1'b1));
		// smallest sgr press, button 0 at the origin
		add_row(CH_ESC, 1'b0, 1, 0, '0);
		add_row(CH_BRK, 1'b0, 1, 0, '0);
		add_row(CH_LT, 1'b0, 1, 0, '0);
		add_row(CH_0, 1'b0, 1, 0, '0);
		add_row(CH_SEMI, 1'b0, 1, 0, '0);
		add_row(CH_0 + 8'd1, 1'b0, 1, 0, '0);
		add_row(CH_SEMI, 1'b0, 1, 0, '0);
		add_row(CH_0 + 8'd1, 1'b0, 1, 0, '0);
		add_row(CH_PRESS, 1'b1, 1, 1, '{kind: tmsp_pkg::RES_EVENT, etype: tmsp_pkg::EV_DOWN,
			bend: 1'b1, nev: 16'd1, default: '0});
		// x10 with extreme raw bytes
		add_row(CH_ESC, 1'b0, 0, 0, '0);
		add_row(CH_BRK, 1'b0, 0, 0, '0);
		add_row(CH_PRESS, 1'b0, 0, 0, '0);
		add_row(8'hff, 1'b0, 0, 0, '0);
		add_row(8'h00, 1'b0, 0, 0, '0);
		add_row(8'hff, 1'b1, 0, 0, '0);
		// semicolon with no digits, then bytes ignored to the end of the buffer
		add_row(CH_ESC, 1'b0, 0, 0, '0);
		add_row(CH_BRK, 1'b0, 0, 0, '0);
		add_row(CH_LT, 1'b0, 0, 0, '0);
		add_row(CH_SEMI, 1'b0, 1, 1, stop_result(16'd0, 1'b0));
		add_row(8'h78, 1'b1, 1, 0, '0);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].has,
				dir_rows[i].res);

		sent = 0;
		while (sent < RANDOM_LEN) begin
			burst = ($urandom_range(0, 4) == 0);
			buf_bytes.delete();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) buf_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				nrep = $urandom_range(1, 5);
				cut  = 1'b0;
				for (int i = 0; i < nrep && !cut; i++) begin
					build_report();
					if ($urandom_range(0, 9) == 0)
						frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
							8'($urandom_range(0, 255));
					if ($urandom_range(0, 11) == 0) begin
						frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
						cut = 1'b1;
					end
					foreach (frame_bytes[j]) buf_bytes.push_back(frame_bytes[j]);
				end
			end
			foreach (buf_bytes[i]) begin
				send_byte(buf_bytes[i], i == buf_bytes.size() - 1, 0, 0, '0);
				sent++;
			end
		end
		burst = 1'b0;
		byte_ch.valid <= 1'b0;

		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_LEN) @(posedge clk);
		if (fail_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
src/tmsp_pkg.sv
src/tmsp_if.sv
src/tmsp_front.sv
src/tmsp_queue.sv
src/tmsp_back.sv
src/terminal_mouse_sequence_parser.sv
dv/tb_top.sv
